FILE: src/ckt_pkg.sv
// ----------------------------------------------------------------------------
// ckt_pkg
// Shared types and constants for the client keepalive table.
// ----------------------------------------------------------------------------
package ckt_pkg;

    localparam int MAX_CLIENTS = 64;
    localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int ID_W        = 16;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PW        = $clog2(Q_DEPTH);

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [MAX_CLIENTS-1:0] t_slots;
    typedef logic [ID_W-1:0]        t_id;

    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_kind kind;
        logic  is_tick;
        t_id   client_id;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_q_head;

endpackage

FILE: src/client_keepalive_table_top.sv
// ----------------------------------------------------------------------------
// client_keepalive_table_top
// Registered client table with activity marks and a silence check on each tick request.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are carried out one at a time by the
// table engine. Add, remove and refresh pass through three engine states (take
// from the queue, parallel id match over all slots, table update and result)
// and give one result. A tick starts from idle, then scans the slots one per
// cycle up to the highest silent client and moves to an emit state for each
// client it reports, waiting there while the output register is full; a tick
// that finds nobody silent goes from idle to a single empty report. The scan
// rate is set by the single read port of the id store. Results sit in an
// output register, so the queue keeps taking requests while a result waits.
// ----------------------------------------------------------------------------
module client_keepalive_table_top
    import ckt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_client_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_offline_id,
    output logic        o_is_offline,
    output logic        o_last
);

    t_q_head w_head;
    logic    w_pop;

    ckt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_client_id (i_client_id),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    ckt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_offline_id (o_offline_id),
        .o_is_offline (o_is_offline),
        .o_last       (o_last)
    );

endmodule

FILE: src/ckt_front.sv
// ----------------------------------------------------------------------------
// ckt_front
// Accepts request transactions, classifies them and holds them in a short
// queue until the table engine takes them.
// ----------------------------------------------------------------------------
module ckt_front
    import ckt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_client_id,
    output t_q_head o_head,
    input  logic    i_pop
);

    t_req            r_q [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr;
    logic [Q_PW:0]   r_count;
    logic [Q_PW:0]   n_count;
    logic            w_push;
    logic            w_pop;
    t_req            w_req;

    assign o_ready = (r_count != (Q_PW+1)'(Q_DEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != '0);

    always_comb begin
        w_req.kind      = t_kind'(i_kind);
        w_req.is_tick   = (t_kind'(i_kind) == KIND_TICK);
        w_req.client_id = i_client_id;
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_req;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_q[r_rd_ptr];

endmodule

FILE: src/ckt_back.sv
// ----------------------------------------------------------------------------
// ckt_back
// Table engine: id match, slot update, tick scan and the result register.
// ----------------------------------------------------------------------------
module ckt_back
    import ckt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_offline_id,
    output logic        o_is_offline,
    output logic        o_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MATCH = 6'b000010,
        S_APPLY = 6'b000100,
        S_SCAN  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_EMPTY = 6'b100000
    } t_state;

    localparam t_slots SLOT_ONE = t_slots'(1);

    t_state  r_state, n_state;
    t_slots  r_valid;
    t_slots  r_active;
    t_slots  r_pend;
    t_idx    r_idx;
    logic    r_scan_last;
    t_req    r_req;
    logic    r_hit;
    t_idx    r_hit_idx;
    logic    r_full;
    t_idx    r_free_idx;
    t_id     r_cam_id [MAX_CLIENTS];
    t_id     r_mem    [MAX_CLIENTS];
    t_id     r_rd_data;

    logic    r_o_valid;
    t_status r_o_status;
    t_id     r_o_offline_id;
    logic    r_o_is_offline;
    logic    r_o_last;

    logic    w_out_free;
    logic    w_load;
    logic    w_hit;
    t_idx    w_hit_idx;
    logic    w_full;
    t_idx    w_free_idx;
    t_slots  w_pend;
    t_slots  w_idx_mask;
    logic    w_mem_we;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_load     = w_out_free && ((r_state == S_APPLY) || (r_state == S_EMIT)
                                       || (r_state == S_EMPTY));
    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_pend     = r_valid & ~r_active;
    assign w_idx_mask = SLOT_ONE << r_idx;

    // Parallel id match; ids are unique among valid slots, so OR-encode the hit
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            if (r_valid[i] && (r_cam_id[i] == r_req.client_id)) begin
                w_hit     = 1'b1;
                w_hit_idx = w_hit_idx | t_idx'(i);
            end
        end
    end

    // Lowest free slot
    always_comb begin
        w_full     = 1'b1;
        w_free_idx = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_full     = 1'b0;
                w_free_idx = t_idx'(i);
            end
        end
    end

    assign w_mem_we = (r_state == S_APPLY) && w_out_free && (r_req.kind == KIND_ADD)
                      && !r_hit && !r_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.req.is_tick) begin
                        n_state = (w_pend == '0) ? S_EMPTY : S_SCAN;
                    end else begin
                        n_state = S_MATCH;
                    end
                end
            end
            S_MATCH: n_state = S_APPLY;
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_pend[r_idx]) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = r_scan_last ? S_IDLE : S_SCAN;
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_active  <= '0;
            r_pend    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid && i_head.req.is_tick) begin
                        // snapshot silent clients, then drop all marks
                        r_pend   <= w_pend;
                        r_active <= '0;
                    end
                end
                S_APPLY: begin
                    if (w_out_free) begin
                        if (r_req.kind == KIND_ADD) begin
                            if (!r_hit && !r_full) begin
                                r_valid[r_free_idx]  <= 1'b1;
                                r_active[r_free_idx] <= 1'b0;
                            end
                        end else if (r_hit) begin
                            if (r_req.kind == KIND_REMOVE) begin
                                r_valid[r_hit_idx]  <= 1'b0;
                                r_active[r_hit_idx] <= 1'b0;
                            end else begin
                                r_active[r_hit_idx] <= 1'b1;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pend[r_idx]) begin
                        r_pend[r_idx] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    r_req <= i_head.req;
                    r_idx <= '0;
                end
            end
            S_MATCH: begin
                r_hit      <= w_hit;
                r_hit_idx  <= w_hit_idx;
                r_full     <= w_full;
                r_free_idx <= w_free_idx;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    r_o_offline_id <= '0;
                    r_o_is_offline <= 1'b0;
                    r_o_last       <= 1'b1;
                    if (r_req.kind == KIND_ADD) begin
                        if (r_hit) begin
                            r_o_status <= ST_DUP;
                        end else if (r_full) begin
                            r_o_status <= ST_FULL;
                        end else begin
                            r_o_status           <= ST_OK;
                            r_cam_id[r_free_idx] <= r_req.client_id;
                        end
                    end else begin
                        r_o_status <= r_hit ? ST_OK : ST_UNKNOWN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend[r_idx]) begin
                    r_scan_last <= ((r_pend & ~w_idx_mask) == '0);
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_o_status     <= ST_OK;
                    r_o_offline_id <= r_rd_data;
                    r_o_is_offline <= 1'b1;
                    r_o_last       <= r_scan_last;
                    if (!r_scan_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    r_o_status     <= ST_OK;
                    r_o_offline_id <= '0;
                    r_o_is_offline <= 1'b0;
                    r_o_last       <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Id store for the tick scan: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_free_idx] <= r_req.client_id;
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_offline_id = r_o_offline_id;
    assign o_is_offline = r_o_is_offline;
    assign o_last       = r_o_last;

endmodule

FILE: test/client_keepalive_table_top_tb.sv
// ----------------------------------------------------------------------------
// client_keepalive_table_top_tb
// Self-checking testbench for the client keepalive table.
// ----------------------------------------------------------------------------
// A driver sends add, remove, refresh and tick requests in bursts with random
// gaps. A mirror of the client table predicts the reports for every request
// the block takes. A monitor checks each report against the oldest prediction
// while the result side stalls on its own pattern. The directed requests come
// first. They are followed by random traffic over a small id pool, which
// fills the table and drains it again.
// ----------------------------------------------------------------------------
module client_keepalive_table_top_tb;
    import ckt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int POOL_SIZE      = 96;

    typedef struct {
        t_kind       kind;
        logic [15:0] id;
    } t_request;

    typedef struct {
        t_status     status;
        logic [15:0] offline_id;
        logic        is_offline;
        logic        last;
    } t_report;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_kind       = 2'd0;
    logic [15:0] i_client_id  = 16'd0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_offline_id;
    logic        o_is_offline;
    logic        o_last;

    // mirror of the client table
    logic        mirror_valid  [MAX_CLIENTS];
    logic [15:0] mirror_id     [MAX_CLIENTS];
    logic        mirror_active [MAX_CLIENTS];

    t_request    request_q[$];
    t_report     pending_reports[$];
    logic [15:0] id_pool[POOL_SIZE];

    t_request    next_req;
    t_report     got_report;
    int          burst_left;
    int          gap_left;
    int          ready_left;
    int          idle_cycles;
    int          error_count;
    int          requests_sent;
    int          reports_seen;
    int          offline_seen;
    int          full_seen;

    client_keepalive_table_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_client_id  (i_client_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_offline_id (o_offline_id),
        .o_is_offline (o_is_offline),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the reports of one request and advance the mirror.
    task automatic predict_reports(input t_kind kind, input logic [15:0] id);
        int      hit;
        int      free_slot;
        int      last_silent;
        t_report rep;
        hit         = -1;
        free_slot   = -1;
        last_silent = -1;
        rep         = '{ST_OK, 16'd0, 1'b0, 1'b1};
        if (kind == KIND_TICK) begin
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                if (mirror_valid[i] && !mirror_active[i])
                    last_silent = i;
            end
            if (last_silent < 0) begin
                pending_reports.push_back(rep);
            end
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                if (mirror_valid[i] && !mirror_active[i]) begin
                    pending_reports.push_back('{ST_OK, mirror_id[i], 1'b1,
                                               (i == last_silent)});
                end
                mirror_active[i] = 1'b0;
            end
            return;
        end
        for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
            if (mirror_valid[i] && mirror_id[i] == id)
                hit = i;
            if (!mirror_valid[i])
                free_slot = i;
        end
        if (kind == KIND_ADD) begin
            if (hit >= 0) begin
                rep.status = ST_DUP;
            end else if (free_slot < 0) begin
                rep.status = ST_FULL;
            end else begin
                mirror_valid[free_slot]  = 1'b1;
                mirror_id[free_slot]     = id;
                mirror_active[free_slot] = 1'b0;
            end
        end else if (hit < 0) begin
            rep.status = ST_UNKNOWN;
        end else if (kind == KIND_REMOVE) begin
            mirror_valid[hit]  = 1'b0;
            mirror_active[hit] = 1'b0;
        end else begin
            mirror_active[hit] = 1'b1;
        end
        pending_reports.push_back(rep);
    endtask

    task automatic queue_request(input t_kind kind, input logic [15:0] id);
        request_q.push_back('{kind, id});
    endtask

    // Mixed traffic on the first span ids of the pool, weights in percent;
    // whatever the weights leave over is noise with a fully random id.
    task automatic queue_mixed(input int count, input int span, input int w_add,
                               input int w_rem, input int w_ref, input int w_tick);
        int          pick;
        logic [15:0] id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            id   = id_pool[$urandom_range(0, span - 1)];
            if (pick < w_add) begin
                queue_request(KIND_ADD, id);
            end else if (pick < w_add + w_rem) begin
                queue_request(KIND_REMOVE, id);
            end else if (pick < w_add + w_rem + w_ref) begin
                queue_request(KIND_REFRESH, id);
            end else if (pick < w_add + w_rem + w_ref + w_tick) begin
                queue_request(KIND_TICK, 16'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0:       queue_request(KIND_ADD, 16'($urandom));
                    1:       queue_request(KIND_REMOVE, 16'($urandom));
                    default: queue_request(KIND_REFRESH, 16'($urandom));
                endcase
            end
        end
    endtask

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left   = 0;
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                mirror_valid[i]  = 1'b0;
                mirror_active[i] = 1'b0;
            end
        end else begin
            if (i_valid && o_ready) begin
                predict_reports(t_kind'(i_kind), i_client_id);
                requests_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    next_req = request_q.pop_front();
                    i_valid     <= 1'b1;
                    i_kind      <= next_req.kind;
                    i_client_id <= next_req.id;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: ready runs and stalls of random length.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b1;
            ready_left = $urandom_range(1, 10);
        end else if (ready_left > 0) begin
            ready_left--;
        end else begin
            i_ready <= !i_ready;
            if (!i_ready)
                ready_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
            else
                ready_left = $urandom_range(0, 6);
        end
    end

    // Monitor: compare each transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            reports_seen++;
            if (o_is_offline)
                offline_seen++;
            if (o_status == ST_FULL)
                full_seen++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, status %0d offline_id %h", $time,
                         o_status, o_offline_id);
                error_count++;
            end else begin
                got_report = pending_reports.pop_front();
                if (o_status !== got_report.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             got_report.status, o_status);
                    error_count++;
                end
                if (o_offline_id !== got_report.offline_id) begin
                    $display("%0t: offline_id mismatch, expected %h, got %h", $time,
                             got_report.offline_id, o_offline_id);
                    error_count++;
                end
                if (o_is_offline !== got_report.is_offline) begin
                    $display("%0t: is_offline mismatch, expected %0b, got %0b", $time,
                             got_report.is_offline, o_is_offline);
                    error_count++;
                end
                if (o_last !== got_report.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b", $time,
                             got_report.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles   = 0;
        error_count   = 0;
        requests_sent = 0;
        reports_seen  = 0;
        offline_seen  = 0;
        full_seen     = 0;
        // distinct pool ids: low bits carry the index
        for (int k = 0; k < POOL_SIZE; k++)
            id_pool[k] = (16'($urandom) & 16'hFF80) | 16'(k);

        // directed: extreme ids, duplicates, unknown ids, ticks with and
        // without silent clients, reuse of the lowest free slot
        queue_request(KIND_ADD,     16'h0000);
        queue_request(KIND_ADD,     16'hFFFF);
        queue_request(KIND_ADD,     16'h0000);
        queue_request(KIND_REFRESH, 16'hFFFF);
        queue_request(KIND_REFRESH, 16'h5A5A);
        queue_request(KIND_REMOVE,  16'hA5A5);
        queue_request(KIND_TICK,    16'hFFFF);
        queue_request(KIND_TICK,    16'h0000);
        queue_request(KIND_REFRESH, 16'h0000);
        queue_request(KIND_REFRESH, 16'hFFFF);
        queue_request(KIND_TICK,    16'h1234);
        queue_request(KIND_REMOVE,  16'h0000);
        queue_request(KIND_ADD,     16'h8001);
        queue_request(KIND_REMOVE,  16'hFFFF);
        queue_request(KIND_REMOVE,  16'hFFFF);
        queue_request(KIND_REFRESH, 16'h0000);
        queue_request(KIND_TICK,    16'h0000);
        queue_request(KIND_REMOVE,  16'h8001);
        queue_request(KIND_TICK,    16'hFFFF);

        // random: mixed traffic on the first 40 pool ids
        queue_mixed(100, 40, 35, 20, 30, 8);

        // fill the table, hit table full, then tick with most clients silent
        for (int k = 0; k < 72; k++) begin
            queue_request(KIND_ADD, id_pool[k]);
            if ($urandom_range(0, 2) == 0)
                queue_request(KIND_REFRESH, id_pool[$urandom_range(0, k)]);
            if (k % 20 == 19)
                queue_request(KIND_TICK, 16'($urandom));
        end
        queue_request(KIND_ADD, id_pool[3]);
        queue_request(KIND_TICK, 16'($urandom));
        for (int k = 0; k < 10; k++)
            queue_request(KIND_REFRESH, id_pool[$urandom_range(0, 63)]);
        queue_request(KIND_TICK, 16'($urandom));

        // drain and mix over the whole pool
        queue_mixed(60, POOL_SIZE, 10, 50, 25, 8);
        queue_mixed(140, POOL_SIZE, 35, 20, 30, 8);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!((request_q.size() == 0 && !i_valid && pending_reports.size() == 0)
                 || idle_cycles >= WATCHDOG_LIMIT))
            @(negedge i_clk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_reports.size());
            $display("Test completed with failures");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            if (pending_reports.size() != 0) begin
                $display("%0t: %0d expected results never arrived", $time,
                         pending_reports.size());
                error_count++;
            end
            $display("Sent %0d requests, checked %0d results", requests_sent, reports_seen);
            $display("including %0d silent-client reports and %0d table-full replies",
                     offline_seen, full_seen);
            if (error_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
